FILE: src/csvt_pkg.sv
package csvt_pkg;

    localparam logic [7:0] CH_BOM0  = 8'hEF;
    localparam logic [7:0] CH_BOM1  = 8'hBB;
    localparam logic [7:0] CH_BOM2  = 8'hBF;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;

    // Token queue geometry.
    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);
    localparam int QCW    = $clog2(QDEPTH + 1);

    typedef enum logic [1:0] {
        TK_BYTE = 2'd0,
        TK_EOF  = 2'd1,
        TK_EOR  = 2'd2
    } t_kind;

    typedef enum logic {
        RQ_BYTE = 1'b0,
        RQ_EOT  = 1'b1
    } t_req;

    typedef enum logic [3:0] {
        BOM_START = 4'b0001,
        BOM_EF    = 4'b0010,
        BOM_EFBB  = 4'b0100,
        BOM_DONE  = 4'b1000
    } t_bom;

    typedef struct packed {
        logic  last;
        logic [7:0] data;
        t_kind kind;
    } t_token;

    typedef struct packed {
        logic in_quotes;
        logic quote_pending;
        logic row_open;
    } t_qstate;

    typedef struct packed {
        t_qstate st;
        logic    vld;
        t_token  tok;
    } t_take;

    localparam t_qstate QSTATE_RESET = '{in_quotes: 1'b0, quote_pending: 1'b0, row_open: 1'b0};

    // One byte through the quoting rules; at most one token comes out.
    function automatic t_take take_byte(input t_qstate st, input logic [7:0] c);
        t_take r;
        logic  unq;
        r = '{st: st, vld: 1'b0, tok: '{last: 1'b0, data: 8'h00, kind: TK_BYTE}};
        unq = 1'b1;
        if (st.in_quotes && !st.quote_pending) begin
            unq = 1'b0;
            if (c == CH_QUOTE) begin
                r.st.quote_pending = 1'b1;
            end else begin
                r.vld = 1'b1;
                r.tok.data = c;
            end
        end else if (st.in_quotes) begin
            // A quote was waiting: a second quote makes it literal, anything else closes.
            r.st.quote_pending = 1'b0;
            if (c == CH_QUOTE) begin
                unq = 1'b0;
                r.vld = 1'b1;
                r.tok.data = CH_QUOTE;
            end else begin
                r.st.in_quotes = 1'b0;
            end
        end
        if (unq) begin
            unique case (c)
                CH_QUOTE: begin
                    r.st.in_quotes = 1'b1;
                    r.st.row_open = 1'b1;
                end
                CH_COMMA: begin
                    r.vld = 1'b1;
                    r.tok.kind = TK_EOF;
                    r.st.row_open = 1'b1;
                end
                CH_CR: begin
                end
                CH_LF: begin
                    r.vld = 1'b1;
                    r.tok.kind = TK_EOR;
                    r.st.row_open = 1'b0;
                end
                default: begin
                    r.vld = 1'b1;
                    r.tok.data = c;
                    r.st.row_open = 1'b1;
                end
            endcase
        end
        return r;
    endfunction

endpackage

FILE: src/csv_byte_tokenizer.sv
// CSV byte tokenizer. Each slave transfer carries one text byte (tuser low) or an
// end-of-text mark (tuser high); each master transfer carries one token: a field byte,
// an end of field, or an end of field and row, with tlast on the last token that an
// input transfer caused. A leading byte order mark is removed, quoted sections keep
// commas and newlines as data, and end of text closes an open row and resets the parser.
// Each item sits in an input register and is parsed combinationally into the four-entry token
// queue, drained one token per cycle by the master port while it is ready. Items are taken at
// one per cycle only while that queue holds at most one entry, room for the worst case of
// three tokens (a broken byte order mark, or end of text); any item, whatever it gives, holds
// the input back until the queue is down to one entry.
module csv_byte_tokenizer
    import csvt_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] text_byte
    input  logic        i_s_tuser,   // [0] req_type
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [15:0] o_m_tdata,   // [1:0] token_kind, [9:2] field_byte, [15:10] zero
    output logic        o_m_tlast    // last_of_run
);

    logic         r_in_valid;
    t_req         r_in_req;
    logic [7:0]   r_in_byte;
    logic         consume;
    logic         room;
    t_token [2:0] tok;
    logic [1:0]   tok_n;
    t_token       head;

    assign consume    = r_in_valid && room;
    assign o_s_tready = !r_in_valid || consume;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_s_tvalid && o_s_tready) begin
            r_in_req  <= t_req'(i_s_tuser);
            r_in_byte <= i_s_tdata;
        end
    end

    csvt_parse u_parse (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (consume),
        .i_req   (r_in_req),
        .i_byte  (r_in_byte),
        .o_tok   (tok),
        .o_tok_n (tok_n)
    );

    csvt_tokq u_tokq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_tok    (tok),
        .i_push_n (tok_n),
        .o_room   (room),
        .o_valid  (o_m_tvalid),
        .i_ready  (i_m_tready),
        .o_tok    (head)
    );

    assign o_m_tdata = {6'b000000, head.data, head.kind};
    assign o_m_tlast = head.last;

endmodule

FILE: src/csvt_parse.sv
module csvt_parse
    import csvt_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  t_req             i_req,
    input  logic [7:0]       i_byte,
    output t_token [2:0]     o_tok,
    output logic [1:0]       o_tok_n
);

    t_qstate r_st, n_st;
    t_bom    r_bom, n_bom;

    logic    replay_ef, replay_bb, take_c;
    t_take   t0, t1, t2;
    t_qstate st1, st2;
    logic    v0, v1, v2;
    t_token  s0, s1, s2;
    t_token  c0, c1, c2;
    logic [1:0] cnt;

    always_comb begin
        replay_ef = 1'b0;
        replay_bb = 1'b0;
        take_c    = 1'b1;
        n_bom     = BOM_DONE;
        unique case (r_bom)
            BOM_START: begin
                if (i_req == RQ_BYTE && i_byte == CH_BOM0) begin
                    take_c = 1'b0;
                    n_bom  = BOM_EF;
                end
            end
            BOM_EF: begin
                replay_ef = (i_req == RQ_EOT) || (i_byte != CH_BOM1);
                if (i_req == RQ_BYTE && i_byte == CH_BOM1) begin
                    take_c = 1'b0;
                    n_bom  = BOM_EFBB;
                end
            end
            BOM_EFBB: begin
                replay_ef = (i_req == RQ_EOT) || (i_byte != CH_BOM2);
                replay_bb = replay_ef;
                take_c    = replay_ef;
            end
            BOM_DONE: begin
            end
            default: begin
            end
        endcase

        // Replayed mark bytes go through the quoting rules ahead of the current byte.
        t0  = take_byte(r_st, CH_BOM0);
        st1 = replay_ef ? t0.st : r_st;
        v0  = replay_ef && t0.vld;
        s0  = t0.tok;
        t1  = take_byte(st1, CH_BOM1);
        st2 = replay_bb ? t1.st : st1;
        v1  = replay_bb && t1.vld;
        s1  = t1.tok;
        t2  = take_byte(st2, i_byte);

        if (i_req == RQ_EOT) begin
            v2    = st2.row_open;
            s2    = '{last: 1'b0, data: 8'h00, kind: TK_EOR};
            n_st  = QSTATE_RESET;
            n_bom = BOM_START;
        end else begin
            v2   = take_c && t2.vld;
            s2   = t2.tok;
            n_st = take_c ? t2.st : st2;
        end

        c0  = v0 ? s0 : (v1 ? s1 : s2);
        c1  = (v0 && v1) ? s1 : s2;
        c2  = s2;
        cnt = 2'(v0) + 2'(v1) + 2'(v2);
        c0.last = (cnt == 2'd1);
        c1.last = (cnt == 2'd2);
        c2.last = (cnt == 2'd3);
    end

    assign o_tok   = {c2, c1, c0};
    assign o_tok_n = i_en ? cnt : 2'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st  <= QSTATE_RESET;
            r_bom <= BOM_START;
        end else if (i_en) begin
            r_st  <= n_st;
            r_bom <= n_bom;
        end
    end

endmodule

FILE: src/csvt_tokq.sv
module csvt_tokq
    import csvt_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_token [2:0]     i_tok,
    input  logic [1:0]       i_push_n,
    output logic             o_room,
    output logic             o_valid,
    input  logic             i_ready,
    output t_token           o_tok
);

    t_token           r_q [QDEPTH];
    logic [QAW-1:0]   r_wptr;
    logic [QAW-1:0]   r_rptr;
    logic [QCW-1:0]   r_count;
    logic             pop;

    assign o_valid = (r_count != '0);
    assign o_tok   = r_q[r_rptr];
    assign pop     = o_valid && i_ready;
    // Room for a worst-case burst of three tokens.
    assign o_room  = (r_count <= QCW'(QDEPTH - 3));

    always_ff @(posedge i_clk) begin
        for (int j = 0; j < 3; j++) begin
            if (2'(j) < i_push_n) begin
                r_q[r_wptr + QAW'(j)] <= i_tok[j];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= r_wptr + QAW'(i_push_n);
            r_rptr  <= r_rptr + QAW'(pop);
            r_count <= r_count + QCW'(i_push_n) - QCW'(pop);
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= QCW'(QDEPTH))
        else $error("token queue overflow");

    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push_n != 2'd0 |-> r_count <= QCW'(QDEPTH - 3))
        else $error("tokens pushed without room");

    a_last_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push_n == 2'd1 |-> i_tok[0].last)
        else $error("single token not marked last");

    a_last_three: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push_n == 2'd3 |-> !i_tok[0].last && !i_tok[1].last && i_tok[2].last)
        else $error("burst of three marked wrongly");

endmodule

FILE: tb/sv/csv_token_checker.sv
`timescale 1ns / 1ps

module csv_token_checker
    import csvt_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] text_byte
    input  logic        i_s_tuser,   // [0] req_type
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [15:0] i_m_tdata,   // [1:0] token_kind, [9:2] field_byte, [15:10] zero
    input  logic        i_m_tlast,   // last_of_run
    output int          o_fail_count,
    output int          o_pending,
    output int          o_tokens_checked
);

    typedef struct {
        t_kind      kind;
        logic [7:0] fbyte;
        logic       last;
    } t_exp_token;

    // Parser state as the tokenizer should hold it.
    logic quoted;
    logic quote_waiting;
    logic row_started;
    t_bom bom_state;

    t_exp_token run_tokens[$];
    t_exp_token expected_tokens[$];

    task automatic push_token(input t_kind kind, input logic [7:0] b);
        t_exp_token t;
        t.kind  = kind;
        t.fbyte = (kind == TK_BYTE) ? b : 8'h00;
        t.last  = 1'b0;
        run_tokens.insert(run_tokens.size(), t);
    endtask

    task automatic apply_quoting(input logic [7:0] c);
        if (quoted) begin
            if (quote_waiting) begin
                // A second quote is literal; anything else closes the section and
                // is then handled as an unquoted byte.
                quote_waiting = 1'b0;
                if (c == CH_QUOTE) begin
                    push_token(TK_BYTE, CH_QUOTE);
                    return;
                end
                quoted = 1'b0;
            end else begin
                if (c == CH_QUOTE) begin
                    quote_waiting = 1'b1;
                end else begin
                    push_token(TK_BYTE, c);
                end
                return;
            end
        end
        case (c)
            CH_QUOTE: begin
                quoted      = 1'b1;
                row_started = 1'b1;
            end
            CH_COMMA: begin
                push_token(TK_EOF, 8'h00);
                row_started = 1'b1;
            end
            CH_CR: begin
                // A bare carriage return is dropped.
            end
            CH_LF: begin
                push_token(TK_EOR, 8'h00);
                row_started = 1'b0;
            end
            default: begin
                push_token(TK_BYTE, c);
                row_started = 1'b1;
            end
        endcase
    endtask

    task automatic replay_bom_prefix();
        if (bom_state == BOM_EF || bom_state == BOM_EFBB) begin
            apply_quoting(CH_BOM0);
        end
        if (bom_state == BOM_EFBB) begin
            apply_quoting(CH_BOM1);
        end
        bom_state = BOM_DONE;
    endtask

    task automatic clear_parser();
        quoted        = 1'b0;
        quote_waiting = 1'b0;
        row_started   = 1'b0;
        bom_state     = BOM_START;
    endtask

    task automatic tokenize_item(input t_req req, input logic [7:0] c);
        logic swallowed;
        t_exp_token t;
        swallowed = 1'b0;
        run_tokens.delete();
        if (req == RQ_EOT) begin
            replay_bom_prefix();
            if (row_started) begin
                push_token(TK_EOR, 8'h00);
            end
            clear_parser();
        end else begin
            case (bom_state)
                BOM_START: begin
                    if (c == CH_BOM0) begin
                        bom_state = BOM_EF;
                        swallowed = 1'b1;
                    end else begin
                        bom_state = BOM_DONE;
                    end
                end
                BOM_EF: begin
                    if (c == CH_BOM1) begin
                        bom_state = BOM_EFBB;
                        swallowed = 1'b1;
                    end else begin
                        replay_bom_prefix();
                    end
                end
                BOM_EFBB: begin
                    if (c == CH_BOM2) begin
                        bom_state = BOM_DONE;
                        swallowed = 1'b1;
                    end else begin
                        replay_bom_prefix();
                    end
                end
                default: begin
                end
            endcase
            if (!swallowed) begin
                apply_quoting(c);
            end
        end
        foreach (run_tokens[k]) begin
            t = run_tokens[k];
            t.last = (k == run_tokens.size() - 1);
            expected_tokens.insert(expected_tokens.size(), t);
        end
    endtask

    always @(posedge i_clk) begin : check_tokens
        t_exp_token want;
        if (!i_rst_n) begin
            clear_parser();
            expected_tokens.delete();
        end else begin
            if (i_s_tvalid && i_s_tready) begin
                tokenize_item(t_req'(i_s_tuser), i_s_tdata);
            end
            if (i_m_tvalid && i_m_tready) begin
                o_tokens_checked++;
                if (expected_tokens.size() == 0) begin
                    $error("token with none expected: kind %0d, byte %02h, last %0b",
                           i_m_tdata[1:0], i_m_tdata[9:2], i_m_tlast);
                    o_fail_count++;
                end else begin
                    want = expected_tokens.pop_front();
                    if (i_m_tdata[1:0] != want.kind) begin
                        $error("token_kind: expected %0d, actual %0d",
                               want.kind, i_m_tdata[1:0]);
                        o_fail_count++;
                    end
                    if (i_m_tdata[9:2] != want.fbyte) begin
                        $error("field_byte: expected %02h, actual %02h",
                               want.fbyte, i_m_tdata[9:2]);
                        o_fail_count++;
                    end
                    if (i_m_tlast != want.last) begin
                        $error("last_of_run: expected %0b, actual %0b",
                               want.last, i_m_tlast);
                        o_fail_count++;
                    end
                    if (i_m_tdata[15:10] != 6'd0) begin
                        $error("tdata padding: expected 00, actual %02h", i_m_tdata[15:10]);
                        o_fail_count++;
                    end
                end
            end
        end
        o_pending = expected_tokens.size();
    end

endmodule

FILE: tb/sv/csv_byte_tokenizer_test.sv
`timescale 1ns / 1ps

module csv_byte_tokenizer_test;
    import csvt_pkg::*;

    localparam int CYCLE_LIMIT   = 200000;
    localparam int ITEM_TARGET   = 250;
    localparam int SETTLE_CYCLES = 20;
    localparam int LONG_HOLD     = 120;

    typedef struct {
        t_req       req;
        logic [7:0] chr;
    } t_text_item;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_s_tvalid;
    logic        o_s_tready;
    logic [7:0]  i_s_tdata;   // [7:0] text_byte
    logic        i_s_tuser;   // [0] req_type
    logic        o_m_tvalid;
    logic        i_m_tready;
    logic [15:0] o_m_tdata;   // [1:0] token_kind, [9:2] field_byte, [15:10] zero
    logic        o_m_tlast;   // last_of_run

    t_text_item stimulus[$];
    int  cycle_count = 0;
    int  sent_items = 0;
    int  sent_texts = 0;
    int  fail_count;
    int  pending;
    int  tokens_checked;
    bit  src_gaps_on;

    always #5 i_clk = ~i_clk;

    csv_byte_tokenizer dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast)
    );

    csv_token_checker u_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_s_tvalid       (i_s_tvalid),
        .i_s_tready       (o_s_tready),
        .i_s_tdata        (i_s_tdata),
        .i_s_tuser        (i_s_tuser),
        .i_m_tvalid       (o_m_tvalid),
        .i_m_tready       (i_m_tready),
        .i_m_tdata        (o_m_tdata),
        .i_m_tlast        (o_m_tlast),
        .o_fail_count     (fail_count),
        .o_pending        (pending),
        .o_tokens_checked (tokens_checked)
    );

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // Token sink: random stalls, steady stretches, and a couple of long hold-offs
    // started while the source is still offering bytes.
    initial begin
        int stall_left;
        int holds_done;
        int r;
        bit sink_steady;
        stall_left  = 0;
        holds_done  = 0;
        sink_steady = 1'b0;
        i_m_tready  = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (cycle_count % 128 == 0) begin
                sink_steady = ($urandom_range(0, 3) == 0);
            end
            r = $urandom_range(0, 99);
            if (stall_left > 0) begin
                i_m_tready <= 1'b0;
                stall_left--;
            end else if (holds_done < 2 && i_s_tvalid &&
                         cycle_count >= 200 + 350 * holds_done) begin
                i_m_tready <= 1'b0;
                stall_left = LONG_HOLD;
                holds_done++;
            end else if (sink_steady || r < 70) begin
                i_m_tready <= 1'b1;
            end else begin
                i_m_tready <= 1'b0;
                stall_left = (r < 95) ? $urandom_range(0, 2) : $urandom_range(8, 30);
            end
        end
    end

    task automatic put_byte(input logic [7:0] c);
        t_text_item it;
        it.req = RQ_BYTE;
        it.chr = c;
        stimulus.insert(stimulus.size(), it);
    endtask

    task automatic put_eot(input logic [7:0] c);
        t_text_item it;
        it.req = RQ_EOT;
        it.chr = c;
        stimulus.insert(stimulus.size(), it);
    endtask

    // All delimiters sit below 8'h80, so setting the top bit turns one into content.
    function automatic logic [7:0] plain_byte();
        logic [7:0] c;
        c = 8'($urandom_range(0, 255));
        if (c == CH_QUOTE || c == CH_COMMA || c == CH_CR || c == CH_LF) begin
            c = c | 8'h80;
        end
        return c;
    endfunction

    function automatic logic [7:0] noise_byte();
        int r;
        r = $urandom_range(0, 99);
        if (r < 12) return CH_QUOTE;
        if (r < 22) return CH_COMMA;
        if (r < 27) return CH_CR;
        if (r < 37) return CH_LF;
        if (r < 40) return CH_BOM0;
        if (r < 43) return CH_BOM1;
        if (r < 45) return CH_BOM2;
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic add_quoted_field();
        int r;
        put_byte(CH_QUOTE);
        repeat ($urandom_range(0, 4)) begin
            r = $urandom_range(0, 99);
            if (r < 15) begin
                put_byte(CH_QUOTE);
                put_byte(CH_QUOTE);
            end else if (r < 25) begin
                put_byte(CH_COMMA);
            end else if (r < 35) begin
                put_byte(CH_LF);
            end else if (r < 40) begin
                put_byte(CH_CR);
            end else begin
                put_byte(plain_byte());
            end
        end
        // Now and then the text ends inside the quotes.
        if ($urandom_range(0, 9) != 0) begin
            put_byte(CH_QUOTE);
        end
    endtask

    task automatic add_text();
        int r;
        int rows;
        int fields;
        r = $urandom_range(0, 99);
        if (r < 25) begin
            put_byte(CH_BOM0);
            put_byte(CH_BOM1);
            put_byte(CH_BOM2);
        end else if (r < 35) begin
            put_byte(CH_BOM0);
        end else if (r < 45) begin
            put_byte(CH_BOM0);
            put_byte(CH_BOM1);
        end
        if ($urandom_range(0, 99) < 15) begin
            repeat ($urandom_range(0, 20)) put_byte(noise_byte());
        end else begin
            rows = $urandom_range(1, 3);
            for (int row = 0; row < rows; row++) begin
                fields = $urandom_range(1, 3);
                for (int f = 0; f < fields; f++) begin
                    if (f > 0) put_byte(CH_COMMA);
                    if ($urandom_range(0, 2) == 0) begin
                        add_quoted_field();
                    end else begin
                        repeat ($urandom_range(0, 3)) put_byte(plain_byte());
                    end
                end
                r = $urandom_range(0, 9);
                if (row < rows - 1 || r < 5) begin
                    if (r < 3) put_byte(CH_CR);
                    put_byte(CH_LF);
                end
            end
        end
        put_eot(8'($urandom_range(0, 255)));
    endtask

    task automatic offer(input t_text_item it);
        int gap;
        int r;
        gap = 0;
        if (src_gaps_on) begin
            r = $urandom_range(0, 99);
            if (r >= 92) gap = $urandom_range(6, 25);
            else if (r >= 60) gap = $urandom_range(1, 3);
        end
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= it.chr;
        i_s_tuser  <= it.req;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        sent_items++;
        if (it.req == RQ_EOT) sent_texts++;
        @(negedge i_clk);
    endtask

    initial begin
        i_rst_n    = 1'b0;
        i_s_tvalid = 1'b0;
        i_s_tdata  = 8'h00;
        i_s_tuser  = RQ_BYTE;

        // Empty text.
        put_eot(8'hFF);
        // Full byte order mark, a zero byte, CR dropped, text ending in LF.
        put_byte(CH_BOM0);
        put_byte(CH_BOM1);
        put_byte(CH_BOM2);
        put_byte(8'h00);
        put_byte(CH_COMMA);
        put_byte(CH_CR);
        put_byte(CH_LF);
        put_eot(8'h00);
        // Lone EF replayed before a quote; comma and LF as quoted data, a doubled
        // quote, then a closing quote followed by an ordinary byte.
        put_byte(CH_BOM0);
        put_byte(CH_QUOTE);
        put_byte(CH_COMMA);
        put_byte(CH_LF);
        put_byte(CH_QUOTE);
        put_byte(CH_QUOTE);
        put_byte(CH_QUOTE);
        put_byte(8'hFF);
        put_eot(8'h5A);
        // EF BB cut off by end of text: both replayed, then the row closes.
        put_byte(CH_BOM0);
        put_byte(CH_BOM1);
        put_eot(8'hA5);
        // Still inside quotes at end of text.
        put_byte(CH_QUOTE);
        put_eot(8'h3C);
        // Quote waiting for its partner at end of text.
        put_byte(CH_QUOTE);
        put_byte(CH_QUOTE);
        put_eot(8'hC3);

        while (stimulus.size() < ITEM_TARGET) add_text();

        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;
        src_gaps_on = 1'b1;
        foreach (stimulus[k]) begin
            offer(stimulus[k]);
            if (stimulus[k].req == RQ_EOT) begin
                src_gaps_on = ($urandom_range(0, 9) < 7);
            end
        end
        i_s_tvalid <= 1'b0;

        wait (pending == 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("Fed %0d byte and end-of-text transfers making up %0d texts, with BOM,",
                 sent_items, sent_texts);
        $display("quoting and row-close cases; %0d tokens compared, %0d mismatches.",
                 tokens_checked, fail_count);
        if (fail_count == 0 && pending == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

FILE: sim.f
src/csvt_pkg.sv
src/csvt_parse.sv
src/csvt_tokq.sv
src/csv_byte_tokenizer.sv
tb/sv/csv_token_checker.sv
tb/sv/csv_byte_tokenizer_test.sv
